FILE: rtl/box_overlap_iou_containment_unit_macros.svh
// ---------------------------------------------------------------------------
// box overlap unit assertion macros
// shared same-cycle and next-cycle implication checks on clk_i / rst_ni
// ---------------------------------------------------------------------------
`ifndef BOX_OVERLAP_IOU_CONTAINMENT_UNIT_MACROS_SVH
`define BOX_OVERLAP_IOU_CONTAINMENT_UNIT_MACROS_SVH

// same-cycle implication
`define BOXIOU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("box overlap unit: assertion failed");

// next-cycle implication
`define BOXIOU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("box overlap unit: assertion failed");

`endif

FILE: rtl/boxiou_pkg.sv
// ---------------------------------------------------------------------------
// boxiou_pkg
// shared constants, codes and types of the box overlap unit
// ---------------------------------------------------------------------------
`default_nettype none

package boxiou_pkg;

  localparam int unsigned RATIO_W    = 17;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned NUM_FIELDS = 8;
  localparam int unsigned OUT_DATA_W = ((3 * RATIO_W + 7) / 8) * 8;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;
  localparam logic [RATIO_W-1:0] THR_RESET = 17'h08000;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IOU_THR  = 1'b0,
    CFG_CONT_THR = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/boxiou_front.sv
// ---------------------------------------------------------------------------
// boxiou_front
// accepts box pairs, finds the overlap extents and forms the three areas
// ---------------------------------------------------------------------------
`default_nettype none

module boxiou_front #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          s_valid_i,
  output logic                                               s_ready_o,
  input  wire logic [boxiou_pkg::NUM_FIELDS*COORD_WIDTH-1:0] s_data_i,
  input  wire boxiou_pkg::q_stat_t                           q_stat_i,
  output logic                                               push_o,
  output logic [6*COORD_WIDTH-4:0]                           entry_o
);
  import boxiou_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned EXT_W = CW - 1;
  localparam int unsigned PW    = 2 * EXT_W;
  localparam int unsigned DW    = PW + 1;

  logic signed [CW-1:0] al, at, aw, ah, bl, bt, bw, bh;
  logic signed [CW:0]   ar, ab, br, bb, x0, y0, x1, y1;
  logic signed [CW+1:0] dx, dy;
  logic                 ov_d, en;

  logic             v1_q, v2_q, ov1_q, ov2_q;
  logic [EXT_W-1:0] ex_q, ey_q, aw_q, ah_q, bw_q, bh_q;
  logic [PW-1:0]    inter_q, area_a_q, area_b_q;
  logic [DW-1:0]    uni, smaller;

  assign al = s_data_i[0*CW +: CW];
  assign at = s_data_i[1*CW +: CW];
  assign aw = s_data_i[2*CW +: CW];
  assign ah = s_data_i[3*CW +: CW];
  assign bl = s_data_i[4*CW +: CW];
  assign bt = s_data_i[5*CW +: CW];
  assign bw = s_data_i[6*CW +: CW];
  assign bh = s_data_i[7*CW +: CW];

  always_comb begin
    ar = {al[CW-1], al} + {aw[CW-1], aw};
    ab = {at[CW-1], at} + {ah[CW-1], ah};
    br = {bl[CW-1], bl} + {bw[CW-1], bw};
    bb = {bt[CW-1], bt} + {bh[CW-1], bh};
    x0 = (al > bl) ? {al[CW-1], al} : {bl[CW-1], bl};
    y0 = (at > bt) ? {at[CW-1], at} : {bt[CW-1], bt};
    x1 = (ar < br) ? ar : br;
    y1 = (ab < bb) ? ab : bb;
    dx = {x1[CW], x1} - {x0[CW], x0};
    dy = {y1[CW], y1} - {y0[CW], y0};
    ov_d = (dx > 0) && (dy > 0);
  end

  assign en        = !q_stat_i.full;
  assign s_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_valid_i;
      v2_q <= v1_q;
    end
  end

  // an overlap extent never exceeds the smaller size, so it fits EXT_W bits
  always_ff @(posedge clk_i) begin
    if (en) begin
      ov1_q    <= ov_d;
      ex_q     <= dx[EXT_W-1:0];
      ey_q     <= dy[EXT_W-1:0];
      aw_q     <= aw[CW-1] ? '0 : aw[EXT_W-1:0];
      ah_q     <= ah[CW-1] ? '0 : ah[EXT_W-1:0];
      bw_q     <= bw[CW-1] ? '0 : bw[EXT_W-1:0];
      bh_q     <= bh[CW-1] ? '0 : bh[EXT_W-1:0];
      ov2_q    <= ov1_q;
      inter_q  <= PW'(ex_q) * PW'(ey_q);
      area_a_q <= PW'(aw_q) * PW'(ah_q);
      area_b_q <= PW'(bw_q) * PW'(bh_q);
    end
  end

  always_comb begin
    uni     = {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter_q};
    smaller = (area_a_q < area_b_q) ? {1'b0, area_a_q} : {1'b0, area_b_q};
  end

  assign push_o  = v2_q && en;
  assign entry_o = {ov2_q, inter_q, uni, smaller};

endmodule

`default_nettype wire

FILE: rtl/boxiou_queue.sv
// ---------------------------------------------------------------------------
// boxiou_queue
// short first-in first-out queue between the front and back halves
// ---------------------------------------------------------------------------
`default_nettype none

module boxiou_queue #(
  parameter int unsigned ENTRY_W = 93
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [ENTRY_W-1:0] wdata_i,
  input  wire logic               pop_i,
  output logic [ENTRY_W-1:0]      rdata_o,
  output boxiou_pkg::q_stat_t     stat_o
);
  import boxiou_pkg::*;
  `include "box_overlap_iou_containment_unit_macros.svh"

  logic [ENTRY_W-1:0] mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (Q_PTR_W+1)'(1);
        2'b01:   count_q <= count_q - (Q_PTR_W+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign stat_o.empty = (count_q == '0);

  `BOXIOU_ASSERT_IMPL(a_no_overflow, push_i, !stat_o.full || pop_i)
  `BOXIOU_ASSERT_IMPL(a_no_underflow, pop_i, !stat_o.empty)

endmodule

`default_nettype wire

FILE: rtl/boxiou_frac_div.sv
// ---------------------------------------------------------------------------
// boxiou_frac_div
// pipelined restoring divider, one quotient bit per stage, n * 2^16 / d
// ---------------------------------------------------------------------------
`default_nettype none

module boxiou_frac_div #(
  parameter int unsigned DW = 31
) (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic [DW-1:0]                    n_i,
  input  wire logic [DW-1:0]                    d_i,
  input  wire logic                             zero_i,
  input  wire logic                             one_i,
  output logic [boxiou_pkg::RATIO_W-1:0]        ratio_o
);
  import boxiou_pkg::*;

  logic [DW-1:0]     r_in [FRAC_W];
  logic [DW-1:0]     d_in [FRAC_W];
  logic [FRAC_W-1:0] q_in [FRAC_W];
  logic [FRAC_W-1:0] zero_in, one_in;

  logic [DW-1:0]     r_q [FRAC_W];
  logic [DW-1:0]     d_q [FRAC_W];
  logic [FRAC_W-1:0] q_q [FRAC_W];
  logic [FRAC_W-1:0] zero_q, one_q;

  always_comb begin
    r_in[0]    = n_i;
    d_in[0]    = d_i;
    q_in[0]    = '0;
    zero_in[0] = zero_i;
    one_in[0]  = one_i;
    for (int k = 1; k < FRAC_W; k++) begin
      r_in[k]    = r_q[k-1];
      d_in[k]    = d_q[k-1];
      q_in[k]    = q_q[k-1];
      zero_in[k] = zero_q[k-1];
      one_in[k]  = one_q[k-1];
    end
  end

  for (genvar k = 0; k < FRAC_W; k++) begin : g_stage
    logic [DW:0] r2, rn;
    logic        ge;

    always_comb begin
      r2 = {r_in[k], 1'b0};
      ge = (r2 >= {1'b0, d_in[k]});
      rn = ge ? (r2 - {1'b0, d_in[k]}) : r2;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= rn[DW-1:0];
        d_q[k]    <= d_in[k];
        q_q[k]    <= {q_in[k][FRAC_W-2:0], ge};
        zero_q[k] <= zero_in[k];
        one_q[k]  <= one_in[k];
      end
    end
  end

  assign ratio_o = zero_q[FRAC_W-1] ? '0 :
                   one_q[FRAC_W-1]  ? RATIO_ONE :
                                      {1'b0, q_q[FRAC_W-1]};

endmodule

`default_nettype wire

FILE: rtl/boxiou_back.sv
// ---------------------------------------------------------------------------
// boxiou_back
// takes classified pairs from the queue, divides, applies thresholds
// ---------------------------------------------------------------------------
`default_nettype none

module boxiou_back #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire boxiou_pkg::q_stat_t                   q_stat_i,
  output logic                                       pop_o,
  input  wire logic [6*COORD_WIDTH-4:0]              entry_i,
  input  wire logic [boxiou_pkg::RATIO_W-1:0]        iou_thr_i,
  input  wire logic [boxiou_pkg::RATIO_W-1:0]        cont_thr_i,
  output logic                                       m_valid_o,
  input  wire logic                                  m_ready_i,
  output logic [boxiou_pkg::OUT_DATA_W-1:0]          m_data_o,
  output logic                                       m_user_o
);
  import boxiou_pkg::*;
  `include "box_overlap_iou_containment_unit_macros.svh"

  localparam int unsigned EXT_W = COORD_WIDTH - 1;
  localparam int unsigned PW    = 2 * EXT_W;
  localparam int unsigned DW    = PW + 1;

  logic          en;
  logic          ov;
  logic [PW-1:0] inter;
  logic [DW-1:0] uni, smaller, n_ext;

  logic          vs_q;
  logic [DW-1:0] n_q, du_q, ds_q;
  logic          zero_u_q, one_u_q, zero_c_q, one_c_q;

  logic [FRAC_W-1:0]  vd_q;
  logic [RATIO_W-1:0] iou, cont, sim;
  logic               acc;

  logic               m_valid_q, acc_q;
  logic [RATIO_W-1:0] iou_q, cont_q, sim_q;

  assign en    = !m_valid_q || m_ready_i;
  assign pop_o = en && !q_stat_i.empty;

  assign {ov, inter, uni, smaller} = entry_i;
  assign n_ext = {1'b0, inter};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q      <= 1'b0;
      vd_q      <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      vs_q      <= !q_stat_i.empty;
      vd_q      <= {vd_q[FRAC_W-2:0], vs_q};
      m_valid_q <= vd_q[FRAC_W-1];
    end
  end

  // ratio is 0 without overlap or on a zero area, else 1 if numerator >= denominator
  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q      <= n_ext;
      du_q     <= uni;
      ds_q     <= smaller;
      zero_u_q <= !ov || (uni == '0) || (inter == '0);
      one_u_q  <= (n_ext >= uni);
      zero_c_q <= !ov || (smaller == '0) || (inter == '0);
      one_c_q  <= (n_ext >= smaller);
    end
  end

  boxiou_frac_div #(
    .DW (DW)
  ) u_div_iou (
    .clk_i   (clk_i),
    .en_i    (en),
    .n_i     (n_q),
    .d_i     (du_q),
    .zero_i  (zero_u_q),
    .one_i   (one_u_q),
    .ratio_o (iou)
  );

  boxiou_frac_div #(
    .DW (DW)
  ) u_div_cont (
    .clk_i   (clk_i),
    .en_i    (en),
    .n_i     (n_q),
    .d_i     (ds_q),
    .zero_i  (zero_c_q),
    .one_i   (one_c_q),
    .ratio_o (cont)
  );

  always_comb begin
    acc = !((iou < iou_thr_i) && (cont < cont_thr_i));
    sim = acc ? ((iou > cont) ? iou : cont) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      iou_q  <= iou;
      cont_q <= cont;
      sim_q  <= sim;
      acc_q  <= acc;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = OUT_DATA_W'({sim_q, cont_q, iou_q});
  assign m_user_o  = acc_q;

  // union is never below the smaller area, so iou never beats containment
  `BOXIOU_ASSERT_IMPL(a_iou_le_cont, m_valid_q, iou_q <= cont_q)
  `BOXIOU_ASSERT_IMPL(a_ratio_range, m_valid_q, cont_q <= RATIO_ONE)
  `BOXIOU_ASSERT_IMPL(a_sim_pick, m_valid_q && acc_q, (sim_q == iou_q) || (sim_q == cont_q))

endmodule

`default_nettype wire

FILE: rtl/box_overlap_iou_containment_unit.sv
// ---------------------------------------------------------------------------
// box_overlap_iou_containment_unit: axis-aligned box iou and containment
// one item per cycle sustained while m_axis_tready stays high
// results pass the front, queue and back stages and the two parallel 16-stage divider pipelines
// reset clears all valid state and loads both thresholds with 0.5 (0x08000)
// ---------------------------------------------------------------------------
`default_nettype none

module box_overlap_iou_containment_unit #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          cfg_we_i,
  input  wire logic [boxiou_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  wire logic [boxiou_pkg::RATIO_W-1:0]                cfg_data_i,
  input  wire logic                                          s_axis_tvalid,
  output logic                                               s_axis_tready,
  // a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height
  input  wire logic [boxiou_pkg::NUM_FIELDS*COORD_WIDTH-1:0] s_axis_tdata,
  output logic                                               m_axis_tvalid,
  input  wire logic                                          m_axis_tready,
  // iou_ratio, containment_ratio, similarity, zero pad
  output logic [boxiou_pkg::OUT_DATA_W-1:0]                  m_axis_tdata,
  // accepted
  output logic                                               m_axis_tuser
);
  import boxiou_pkg::*;

  localparam int unsigned ENTRY_W = 6 * COORD_WIDTH - 3;

  logic [RATIO_W-1:0] iou_thr_q, cont_thr_q;
  q_stat_t            q_stat;
  logic               push, pop;
  logic [ENTRY_W-1:0] wentry, rentry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iou_thr_q  <= THR_RESET;
      cont_thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IOU_THR:  iou_thr_q  <= cfg_data_i;
        CFG_CONT_THR: cont_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  boxiou_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .entry_o   (wentry)
  );

  boxiou_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (rentry),
    .stat_o  (q_stat)
  );

  boxiou_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .entry_i    (rentry),
    .iou_thr_i  (iou_thr_q),
    .cont_thr_i (cont_thr_q),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_user_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire
